[hdl/swrl_pkg.sv]
// Package for the sliding-window rate limiter.
// Holds command and configuration codes, field widths and reset values.
// No dependencies.
package swrl_pkg;

  localparam int STAMP_W  = 32;
  localparam int LIMIT_W  = 7;
  localparam int WINDOW_W = 22;
  localparam int HELD_W   = 7;
  localparam int CMD_W    = 2;
  localparam int CFG_IDX_W = 1;

  // Request commands.
  localparam logic [CMD_W-1:0] CMD_CHECK  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_RECORD = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_REQUEST_LIMIT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_MS     = 1'd1;

  localparam logic [LIMIT_W-1:0]  LIMIT_RESET  = 7'd60;
  localparam logic [WINDOW_W-1:0] WINDOW_RESET = 22'd60000;

endpackage

[hdl/swrl_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module swrl_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[hdl/sliding_window_rate_limiter.sv]
// Sliding-window log rate limiter: a ring of request timestamps in a RAM.
// Record, clear, unused, and check on an empty ring: result valid the cycle after the
// request is taken. Other checks step S_READ (RAM read), S_AGE (age subtract on the
// shared subtractor), S_DECIDE (compare) per stamp examined, then S_WAIT for a wait.
// One request at a time; the next is taken the cycle after the result is taken.
// Synchronous active-low reset empties the ring and loads limit 60, window 60000 ms.
module sliding_window_rate_limiter import swrl_pkg::*; #(
  parameter int RING_DEPTH = 64
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [WINDOW_W-1:0]  cfg_wdata,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [CMD_W-1:0]     in_cmd,
  input  logic [STAMP_W-1:0]   in_now_ms,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 out_allowed,
  output logic [WINDOW_W-1:0]  out_wait_ms,
  output logic [HELD_W-1:0]    out_held_count,
  output logic                 out_overflow
);

  localparam int PTR_W = $clog2(RING_DEPTH);
  localparam int CNT_W = $clog2(RING_DEPTH + 1);
  localparam int SUM_W = PTR_W + 1;
  localparam int CMP_W = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_AGE,
    S_DECIDE,
    S_WAIT,
    S_DONE
  } state_t;

  state_t               state_r, state_nxt;
  logic [PTR_W-1:0]     ptr_r, ptr_nxt;
  logic [CNT_W-1:0]     count_r, count_nxt;
  logic [LIMIT_W-1:0]   limit_r, limit_nxt;
  logic [WINDOW_W-1:0]  window_r, window_nxt;
  logic [STAMP_W-1:0]   now_r, now_nxt;
  logic [STAMP_W-1:0]   age_r, age_nxt;
  logic                 allowed_r, allowed_nxt;
  logic [WINDOW_W-1:0]  wait_r, wait_nxt;
  logic                 ovf_r, ovf_nxt;

  logic                 accept;
  logic                 full;
  logic                 below_limit;
  logic                 expired;
  logic [SUM_W-1:0]     wr_sum;
  logic [PTR_W-1:0]     wr_addr;
  logic                 ram_we;
  logic                 ram_re;
  logic [STAMP_W-1:0]   ram_rdata;
  logic [STAMP_W-1:0]   sub_a, sub_b, sub_y;

  assign accept      = in_valid && !in_stall;
  assign in_stall    = (state_r != S_IDLE);
  assign out_valid   = (state_r == S_DONE);
  assign full        = (count_r == CNT_W'(RING_DEPTH));
  assign below_limit = (CMP_W'(count_r) < CMP_W'(limit_r));
  assign expired     = (age_r > STAMP_W'(window_r));

  // Slot after the newest stamp; the sum stays below twice the depth.
  assign wr_sum  = SUM_W'(ptr_r) + SUM_W'(count_r);
  assign wr_addr = (wr_sum >= SUM_W'(RING_DEPTH)) ? PTR_W'(wr_sum - SUM_W'(RING_DEPTH))
                                                  : PTR_W'(wr_sum);
  assign ram_we  = accept && (in_cmd == CMD_RECORD) && !full;
  assign ram_re  = (state_r == S_READ);

  // One subtractor serves both the age of the oldest stamp and the wait time.
  always_comb begin
    if (state_r == S_AGE) begin
      sub_a = now_r;
      sub_b = ram_rdata;
    end else begin
      sub_a = STAMP_W'(window_r);
      sub_b = age_r;
    end
  end
  assign sub_y = sub_a - sub_b;

  swrl_ram #(
    .WIDTH (STAMP_W),
    .DEPTH (RING_DEPTH)
  ) u_ring (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wr_addr),
    .wdata (in_now_ms),
    .re    (ram_re),
    .raddr (ptr_r),
    .rdata (ram_rdata)
  );

  always_comb begin
    state_nxt   = state_r;
    ptr_nxt     = ptr_r;
    count_nxt   = count_r;
    limit_nxt   = limit_r;
    window_nxt  = window_r;
    now_nxt     = now_r;
    age_nxt     = age_r;
    allowed_nxt = allowed_r;
    wait_nxt    = wait_r;
    ovf_nxt     = ovf_r;

    if (cfg_we) begin
      case (cfg_index)
        CFG_REQUEST_LIMIT: limit_nxt = cfg_wdata[LIMIT_W-1:0];
        CFG_WINDOW_MS:     window_nxt = cfg_wdata;
        default: ;
      endcase
    end

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          now_nxt     = in_now_ms;
          allowed_nxt = 1'b0;
          wait_nxt    = '0;
          ovf_nxt     = 1'b0;
          state_nxt   = S_DONE;
          case (in_cmd)
            CMD_CHECK: begin
              if (count_r == '0) begin
                allowed_nxt = below_limit;
              end else begin
                state_nxt = S_READ;
              end
            end
            CMD_RECORD: begin
              if (full) begin
                ovf_nxt = 1'b1;
              end else begin
                count_nxt = count_r + CNT_W'(1);
              end
            end
            CMD_CLEAR: begin
              ptr_nxt   = '0;
              count_nxt = '0;
            end
            default: ;
          endcase
        end
      end
      S_READ: begin
        state_nxt = S_AGE;
      end
      S_AGE: begin
        age_nxt   = sub_y;
        state_nxt = S_DECIDE;
      end
      S_DECIDE: begin
        if (expired) begin
          ptr_nxt   = (ptr_r == PTR_W'(RING_DEPTH - 1)) ? '0 : ptr_r + PTR_W'(1);
          count_nxt = count_r - CNT_W'(1);
          if (count_r == CNT_W'(1)) begin
            // Ring emptied: nothing left to wait for.
            allowed_nxt = (limit_r != '0);
            state_nxt   = S_DONE;
          end else begin
            state_nxt = S_READ;
          end
        end else if (below_limit) begin
          allowed_nxt = 1'b1;
          state_nxt   = S_DONE;
        end else begin
          state_nxt = S_WAIT;
        end
      end
      S_WAIT: begin
        // The oldest stamp is not expired, so its age is at most the window.
        wait_nxt  = sub_y[WINDOW_W-1:0];
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!out_stall) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      ptr_r    <= '0;
      count_r  <= '0;
      limit_r  <= LIMIT_RESET;
      window_r <= WINDOW_RESET;
    end else begin
      state_r  <= state_nxt;
      ptr_r    <= ptr_nxt;
      count_r  <= count_nxt;
      limit_r  <= limit_nxt;
      window_r <= window_nxt;
    end
    now_r     <= now_nxt;
    age_r     <= age_nxt;
    allowed_r <= allowed_nxt;
    wait_r    <= wait_nxt;
    ovf_r     <= ovf_nxt;
  end

  assign out_allowed    = allowed_r;
  assign out_wait_ms    = wait_r;
  assign out_held_count = HELD_W'(count_r);
  assign out_overflow   = ovf_r;

endmodule

[hdl/swrl_checker.sv]
// Port-level checks for the sliding-window rate limiter, bound to the top level.
// Depends on swrl_pkg and sliding_window_rate_limiter.
module swrl_port_props import swrl_pkg::*; #(
  parameter int RING_DEPTH = 64
) (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_stall,
  input logic                out_valid,
  input logic                out_stall,
  input logic                out_allowed,
  input logic [WINDOW_W-1:0] out_wait_ms,
  input logic [HELD_W-1:0]   out_held_count,
  input logic                out_overflow
);

  // Only one request is in flight, so a pending result blocks new requests.
  a_busy_while_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall)
    else $error("request port ready while a result is pending");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("request port not busy after taking a request");

  a_allowed_no_wait: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_allowed) |-> (out_wait_ms == '0 && !out_overflow))
    else $error("allowed result carries a wait or an overflow");

  a_overflow_full: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_overflow) |-> (out_held_count == HELD_W'(RING_DEPTH)))
    else $error("overflow reported while the ring is not full");

  a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_held_count)))
    else $error("stalled result dropped or changed");

endmodule

bind sliding_window_rate_limiter swrl_port_props #(
  .RING_DEPTH (RING_DEPTH)
) u_swrl_port_props (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_stall       (in_stall),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_allowed    (out_allowed),
  .out_wait_ms    (out_wait_ms),
  .out_held_count (out_held_count),
  .out_overflow   (out_overflow)
);

[tb/swrl_checker.sv]
// Checker for the sliding-window rate limiter: watches the request, result and register
// ports, predicts every verdict and compares it with what the block returns.
// Depends on swrl_pkg.
module swrl_checker import swrl_pkg::*; #(
  parameter int RING_DEPTH = 64
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [WINDOW_W-1:0]  cfg_wdata,
  input  logic                 in_valid,
  input  logic                 in_stall,
  input  logic [CMD_W-1:0]     in_cmd,
  input  logic [STAMP_W-1:0]   in_now_ms,
  input  logic                 out_valid,
  input  logic                 out_stall,
  input  logic                 out_allowed,
  input  logic [WINDOW_W-1:0]  out_wait_ms,
  input  logic [HELD_W-1:0]    out_held_count,
  input  logic                 out_overflow,
  output int                   mismatch_count,
  output int                   verdicts_owed
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SHOWN_MAX = 50;

  typedef struct packed {
    logic                allowed;
    logic [WINDOW_W-1:0] wait_ms;
    logic [HELD_W-1:0]   held_count;
    logic                overflow;
  } verdict_t;

  verdict_t            verdicts_due[$];
  logic [STAMP_W-1:0]  stamp_log [RING_DEPTH];
  int unsigned         oldest_slot;
  int unsigned         held_stamps;
  logic [LIMIT_W-1:0]  limit_reg;
  logic [WINDOW_W-1:0] window_reg;
  int unsigned         verdicts_seen;

  task automatic report_mismatch(input string msg);
    if (mismatch_count < SHOWN_MAX)
      $display("mismatch at %0t ns: %s", $time, msg);
    mismatch_count++;
  endtask

  function automatic verdict_t next_verdict(input logic [CMD_W-1:0] cmd,
                                            input logic [STAMP_W-1:0] now);
    verdict_t           v;
    logic [STAMP_W-1:0] age;
    bit                 expiring;
    v = '0;
    case (cmd)
      CMD_CHECK: begin
        // Stamps leave oldest first; ages wrap modulo 2^32 like the time counter.
        expiring = 1'b1;
        while (expiring && held_stamps > 0) begin
          age = now - stamp_log[oldest_slot];
          if (age <= STAMP_W'(window_reg)) begin
            expiring = 1'b0;
          end else begin
            oldest_slot = (oldest_slot + 1) % RING_DEPTH;
            held_stamps--;
          end
        end
        if (held_stamps < limit_reg) begin
          v.allowed = 1'b1;
        end else if (held_stamps > 0) begin
          age = now - stamp_log[oldest_slot];
          if (age < STAMP_W'(window_reg))
            v.wait_ms = WINDOW_W'(STAMP_W'(window_reg) - age);
        end
      end
      CMD_RECORD: begin
        if (held_stamps >= RING_DEPTH) begin
          v.overflow = 1'b1;
        end else begin
          stamp_log[(oldest_slot + held_stamps) % RING_DEPTH] = now;
          held_stamps++;
        end
      end
      CMD_CLEAR: begin
        oldest_slot = 0;
        held_stamps = 0;
      end
      default: ;
    endcase
    v.held_count = HELD_W'(held_stamps);
    return v;
  endfunction

  always @(posedge clk) begin : watch
    verdict_t got;
    verdict_t want;
    if (!rst_n) begin
      oldest_slot = 0;
      held_stamps = 0;
      limit_reg   = LIMIT_RESET;
      window_reg  = WINDOW_RESET;
      verdicts_due.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_REQUEST_LIMIT: limit_reg  = cfg_wdata[LIMIT_W-1:0];
          CFG_WINDOW_MS:     window_reg = cfg_wdata;
          default: ;
        endcase
      end
      if (in_valid && !in_stall)
        verdicts_due.insert(verdicts_due.size(), next_verdict(in_cmd, in_now_ms));
      if (out_valid && !out_stall) begin
        got = '{out_allowed, out_wait_ms, out_held_count, out_overflow};
        if (verdicts_due.size() == 0) begin
          report_mismatch("result arrived with no request outstanding");
        end else begin
          want = verdicts_due.pop_front();
          if (got !== want)
            report_mismatch($sformatf(
              "result %0d: allowed %0b/%0b wait %0d/%0d held %0d/%0d overflow %0b/%0b",
              verdicts_seen, got.allowed, want.allowed, got.wait_ms, want.wait_ms,
              got.held_count, want.held_count, got.overflow, want.overflow));
        end
        verdicts_seen++;
      end
    end
    verdicts_owed = verdicts_due.size();
  end

endmodule

[tb/tb_sliding_window_rate_limiter.sv]
// Top of the rate limiter testbench: clock, reset, register writes, request stimulus
// and receiver stalls; the verdict comes from the mismatch and owed counts of swrl_checker.
// Depends on swrl_pkg, sliding_window_rate_limiter and swrl_checker.
module tb_sliding_window_rate_limiter import swrl_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam int PHASES          = 8;
  localparam int PHASE_REQUESTS  = 250;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int DRAIN_CYCLES    = 20;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [WINDOW_W-1:0]  cfg_wdata;
  logic                 in_valid;
  logic                 in_stall;
  logic [CMD_W-1:0]     in_cmd;
  logic [STAMP_W-1:0]   in_now_ms;
  logic                 out_valid;
  logic                 out_stall;
  logic                 out_allowed;
  logic [WINDOW_W-1:0]  out_wait_ms;
  logic [HELD_W-1:0]    out_held_count;
  logic                 out_overflow;
  int                   mismatch_count;
  int                   verdicts_owed;

  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned hold_req = 0;
  int unsigned requests_sent;

  int unsigned phase_limit [PHASES] = '{60, 64, 127, 0, 5, 1, 20, 0};
  int unsigned phase_window[PHASES] = '{60000, 100, 4194303, 50, 0, 1, 3600000, 0};
  int unsigned phase_send  [PHASES] = '{0, 54, 0, 19, 0, 54, 0, 19};
  int unsigned phase_recv  [PHASES] = '{0, 0, 54, 19, 0, 0, 54, 19};

  always #6 clk = ~clk;

  sliding_window_rate_limiter u_dut (
    .clk, .rst_n, .cfg_we, .cfg_index, .cfg_wdata,
    .in_valid, .in_stall, .in_cmd, .in_now_ms,
    .out_valid, .out_stall, .out_allowed, .out_wait_ms, .out_held_count, .out_overflow
  );

  swrl_checker u_checker (
    .clk, .rst_n, .cfg_we, .cfg_index, .cfg_wdata,
    .in_valid, .in_stall, .in_cmd, .in_now_ms,
    .out_valid, .out_stall, .out_allowed, .out_wait_ms, .out_held_count, .out_overflow,
    .mismatch_count, .verdicts_owed
  );

  // Receiver side: random stalls, or a long hold-off when one is requested.
  initial begin : receiver
    int unsigned hold_left;
    hold_left = 0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req > 0) begin
        hold_left = hold_req;
        hold_req  = 0;
      end
      if (hold_left > 0) begin
        out_stall = 1'b1;
        hold_left--;
      end else begin
        out_stall = ($urandom_range(0, 99) < recv_stall_pct);
      end
    end
  end

  initial begin
    #30_000_000;
    $display("status: fail");
    $finish;
  end

  // Called at a falling edge; returns at the falling edge after the request is taken.
  task automatic send_request(input logic [CMD_W-1:0] cmd, input logic [STAMP_W-1:0] now);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_cmd    = cmd;
    in_now_ms = now;
    in_valid  = 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
    requests_sent++;
  endtask

  task automatic wait_drained();
    in_valid = 1'b0;
    while (verdicts_owed != 0) @(negedge clk);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [WINDOW_W-1:0] value);
    wait_drained();
    cfg_index = idx;
    cfg_wdata = value;
    cfg_we    = 1'b1;
    @(negedge clk);
    cfg_we    = 1'b0;
  endtask

  initial begin : stimulus
    logic [STAMP_W-1:0] clock_ms;
    logic [CMD_W-1:0]   cmd;
    int unsigned        limit;
    int unsigned        window;
    int unsigned        step_max;
    int unsigned        seq_no;
    int unsigned        seq_len;
    int unsigned        pick;
    rst_n     = 1'b0;
    cfg_we    = 1'b0;
    cfg_index = CFG_REQUEST_LIMIT;
    cfg_wdata = '0;
    in_valid  = 1'b0;
    in_cmd    = CMD_CHECK;
    in_now_ms = '0;
    repeat (5) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // Directed part at reset values: empty ring, wrap of the time counter, unused code.
    send_request(CMD_CHECK, 32'h0000_0000);
    send_request(CMD_RECORD, 32'hFFFF_0000);
    send_request(CMD_RECORD, 32'hFFFF_FFFF);
    send_request(CMD_CHECK, 32'h0000_1000);
    send_request(CMD_UNUSED, 32'h1234_5678);
    send_request(CMD_CLEAR, 32'h0000_0000);
    // A limit of zero: refused on an empty ring with nothing to wait for.
    write_register(CFG_REQUEST_LIMIT, 22'd0);
    send_request(CMD_CHECK, 32'd5);
    send_request(CMD_RECORD, 32'd10);
    send_request(CMD_CHECK, 32'd20);
    send_request(CMD_CHECK, 32'd10);
    send_request(CMD_CHECK, 32'd60010);
    send_request(CMD_CHECK, 32'd60011);
    // A zero window keeps a stamp only while its age is zero.
    write_register(CFG_REQUEST_LIMIT, 22'd2);
    write_register(CFG_WINDOW_MS, 22'd0);
    send_request(CMD_RECORD, 32'd100);
    send_request(CMD_RECORD, 32'd100);
    send_request(CMD_CHECK, 32'd100);
    send_request(CMD_CHECK, 32'd101);
    write_register(CFG_REQUEST_LIMIT, 22'd127);
    write_register(CFG_WINDOW_MS, 22'h3F_FFFF);
    send_request(CMD_RECORD, 32'd0);
    send_request(CMD_CHECK, 32'h003F_FFFF);
    send_request(CMD_CHECK, 32'h0040_0000);

    for (int p = 0; p < PHASES; p++) begin
      limit  = phase_limit[p];
      window = phase_window[p];
      if (p == PHASES - 1) begin
        limit  = $urandom_range(0, 127);
        window = $urandom_range(1, 300);
      end
      write_register(CFG_REQUEST_LIMIT, WINDOW_W'(limit));
      write_register(CFG_WINDOW_MS, WINDOW_W'(window));
      send_idle_pct  = phase_send[p];
      recv_stall_pct = phase_recv[p];
      if (p == 2) hold_req = HOLD_OFF_CYCLES;
      step_max = window / 16 + 2;
      if (p % 2 == 1)
        clock_ms = 32'hFFFF_FFFF - $urandom_range(0, 20 * step_max);
      else
        clock_ms = $urandom;
      requests_sent = 0;
      seq_no = 0;
      while (requests_sent < PHASE_REQUESTS) begin
        if (seq_no % 8 == 3) begin
          // A burst of records close together can fill the ring and overflow it.
          seq_len = $urandom_range(60, 70);
          for (int i = 0; i < seq_len; i++) begin
            clock_ms += $urandom_range(0, 1);
            send_request(CMD_RECORD, clock_ms);
          end
          for (int i = 0; i < 3; i++) begin
            clock_ms += $urandom_range(0, step_max);
            send_request(CMD_CHECK, clock_ms);
          end
        end else begin
          seq_len = $urandom_range(10, 40);
          for (int i = 0; i < seq_len; i++) begin
            pick = $urandom_range(0, 99);
            if (pick < 48)      cmd = CMD_CHECK;
            else if (pick < 94) cmd = CMD_RECORD;
            else if (pick < 97) cmd = CMD_CLEAR;
            else                cmd = CMD_UNUSED;
            pick = $urandom_range(0, 99);
            if (pick < 3) begin
              // Out-of-order time: anything the counter can hold.
              send_request(cmd, $urandom);
            end else begin
              if (pick < 6) clock_ms += window + $urandom_range(1, step_max);
              else          clock_ms += $urandom_range(0, step_max);
              send_request(cmd, clock_ms);
            end
          end
        end
        seq_no++;
        if (p == 5 && seq_no == 4) begin
          wait_drained();
          repeat ($urandom_range(5, 30)) @(negedge clk);
        end
      end
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (verdicts_owed != 0)
      $display("%0d results never arrived", verdicts_owed);
    if (mismatch_count == 0 && verdicts_owed == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule

[sliding_window_rate_limiter.f]
hdl/swrl_pkg.sv
hdl/swrl_ram.sv
hdl/sliding_window_rate_limiter.sv
hdl/swrl_checker.sv
tb/swrl_checker.sv
tb/tb_sliding_window_rate_limiter.sv
